@@ rtl/core/ght_pkg.sv @@
// Shared constants, codes and types of the generational handle table.
`timescale 1ns / 1ps

package ght_pkg;

    // Table size and stored payload width.
    localparam int SLOT_COUNT   = 1024;
    localparam int PAYLOAD_BITS = 32;

    // Handle layout: kind in 31:24, generation in 23:12, slot plus one in 11:0.
    localparam int FIELD_W  = 12;
    localparam int GEN_W    = 12;
    localparam int KIND_W   = 8;
    localparam int HANDLE_W = KIND_W + GEN_W + FIELD_W;
    localparam logic [KIND_W-1:0]  KIND_VALUE = 8'd3;
    localparam logic [GEN_W-1:0]   GEN_LAST   = '1;
    localparam logic [FIELD_W-1:0] SLOT_LIMIT = FIELD_W'(SLOT_COUNT);

    // Result field widths.
    localparam int DATA_W  = 32;
    localparam int LIVE_W  = 11;
    localparam int COUNT_W = 32;

    // Slot index and free map geometry: the free map holds one bit per slot,
    // grouped in rows of ROW_BITS slots.
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int ROW_BITS  = 32;
    localparam int COL_W     = $clog2(ROW_BITS);
    localparam int ROW_COUNT = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int IDX_W     = ROW_W + COL_W;

    // Request type codes.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // One slot entry as kept in the slot RAM.
    typedef struct packed {
        logic                    occupied;
        logic                    retired;
        logic [GEN_W-1:0]        generation;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ALLOC_COL,
        S_ALLOC_WRITE,
        S_CHECK,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic decode;
        logic alloc_col;
        logic alloc_write;
        logic check;
        logic emit;
    } ght_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic is_handle_req;
        logic full;
        logic static_ok;
        logic out_free;
    } ght_sts_t;

endpackage

@@ rtl/core/ght_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ght_ctrl.sv @@
// Request sequencer of the generational handle table.
`timescale 1ns / 1ps

module ght_ctrl
    import ght_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ght_sts_t sts,
    output ght_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_alloc && !sts.full)
                begin
                    state_next = S_ALLOC_COL;
                end
                else if (sts.is_handle_req && sts.static_ok)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_ALLOC_COL:
            begin
                state_next = S_ALLOC_WRITE;
            end
            S_ALLOC_WRITE:
            begin
                state_next = S_RESULT;
            end
            S_CHECK:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Commands for the datapath in each state.
    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            S_ALLOC_COL:
            begin
                cmd.alloc_col = 1'b1;
            end
            S_ALLOC_WRITE:
            begin
                cmd.alloc_write = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_RESULT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/ght_datapath.sv @@
// Slot storage, free map, counters and result register of the handle table.
`timescale 1ns / 1ps

module ght_datapath
    import ght_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ght_cmd_t            cmd,
    output ght_sts_t            sts,
    input  logic [1:0]          req_type,
    input  logic [HANDLE_W-1:0] handle_in,
    input  logic [DATA_W-1:0]   payload_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [DATA_W-1:0]   payload_out,
    output logic [LIVE_W-1:0]   live_count,
    output logic [COUNT_W-1:0]  rejected_count
);

    // Slots of a row that exist in the table; an unwritten row reads as these.
    function automatic logic [ROW_BITS-1:0] row_mask(input logic [ROW_W-1:0] row);
        logic [ROW_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            m[b] = (int'(row) * ROW_BITS + b) < SLOT_COUNT;
        end
        return m;
    endfunction

    // Captured request.
    logic [1:0]          req_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [DATA_W-1:0]   payload_reg;

    // Work registers of one request.
    logic [ROW_W-1:0]    row_sel_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_BITS-1:0] row_data_reg;
    logic [1:0]          pend_status_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;
    logic [DATA_W-1:0]   pend_payload_reg;

    // Control state: clearing sweep, free map row marks and summary, counters.
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic [ROW_COUNT-1:0] rowv_reg;
    logic [ROW_COUNT-1:0] rowv_next;
    logic [ROW_COUNT-1:0] summary_reg;
    logic [ROW_COUNT-1:0] summary_next;
    logic [LIVE_W-1:0]    live_reg;
    logic [LIVE_W-1:0]    live_next;
    logic [COUNT_W-1:0]   rej_reg;
    logic [COUNT_W-1:0]   rej_next;

    // Result register.
    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [DATA_W-1:0]   out_payload_reg;
    logic [LIVE_W-1:0]   out_live_reg;
    logic [COUNT_W-1:0]  out_rej_reg;

    // Handle fields and decode.
    logic [FIELD_W-1:0] h_field;
    logic [GEN_W-1:0]   h_gen;
    logic [KIND_W-1:0]  h_kind;
    logic [FIELD_W-1:0] h_slot;
    logic [IDX_W-1:0]   h_idx;
    logic [ROW_W-1:0]   h_row;
    logic [COL_W-1:0]   h_col;
    logic               static_ok;
    logic               is_alloc;
    logic               is_lookup;
    logic               is_release;

    // Free slot search.
    logic [ROW_W-1:0]    first_row;
    logic [ROW_W-1:0]    dec_row;
    logic [ROW_BITS-1:0] fmap_eff;
    logic [COL_W-1:0]    first_col;
    logic [IDX_W-1:0]    col_slot;
    logic [IDX_W-1:0]    alloc_slot;
    logic [ROW_BITS-1:0] alloc_row_new;
    logic [ROW_BITS-1:0] release_row_new;

    // RAM ports.
    logic                ent_we;
    logic [SLOT_W-1:0]   ent_waddr;
    entry_t              ent_wdata;
    logic [SLOT_W-1:0]   ent_raddr;
    logic [ENTRY_W-1:0]  ent_rdata_raw;
    entry_t              ent_rdata;
    logic                fmap_we;
    logic [ROW_W-1:0]    fmap_waddr;
    logic [ROW_BITS-1:0] fmap_wdata;
    logic [ROW_BITS-1:0] fmap_rdata;

    // Check of the stored slot against the handle.
    logic             slot_ok;
    logic             retiring;
    logic [GEN_W-1:0] alloc_gen;

    // Handle decode.
    always_comb
    begin
        h_field    = handle_reg[FIELD_W-1:0];
        h_gen      = handle_reg[FIELD_W +: GEN_W];
        h_kind     = handle_reg[HANDLE_W-1 -: KIND_W];
        h_slot     = h_field - FIELD_W'(1);
        h_idx      = h_slot[IDX_W-1:0];
        h_row      = h_idx[IDX_W-1:COL_W];
        h_col      = h_idx[COL_W-1:0];
        static_ok  = (h_field != '0) && (h_field <= SLOT_LIMIT) &&
                     (h_gen != '0) && (h_kind == KIND_VALUE);
        is_alloc   = (req_reg == REQ_ALLOC);
        is_lookup  = (req_reg == REQ_LOOKUP);
        is_release = (req_reg == REQ_RELEASE);
    end

    // First row of the summary that still has a free slot.
    always_comb
    begin
        first_row = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--)
        begin
            if (summary_reg[i])
            begin
                first_row = ROW_W'(i);
            end
        end
        dec_row = is_alloc ? first_row : h_row;
    end

    // Free map row as read, and its first free slot.
    always_comb
    begin
        fmap_eff = rowv_reg[row_sel_reg] ? fmap_rdata : row_mask(row_sel_reg);
        first_col = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (fmap_eff[b])
            begin
                first_col = COL_W'(b);
            end
        end
        col_slot        = {row_sel_reg, first_col};
        alloc_slot      = {row_sel_reg, col_reg};
        alloc_row_new   = row_data_reg & ~(ROW_BITS'(1) << col_reg);
        release_row_new = fmap_eff | (ROW_BITS'(1) << h_col);
    end

    // Stored slot check.
    always_comb
    begin
        ent_rdata = entry_t'(ent_rdata_raw);
        slot_ok   = ent_rdata.occupied && !ent_rdata.retired &&
                    (ent_rdata.generation == h_gen);
        retiring  = (ent_rdata.generation == GEN_LAST);
        alloc_gen = (ent_rdata.generation == '0) ? GEN_W'(1) : ent_rdata.generation;
    end

    // RAM address and write selection, and next values of the control state.
    always_comb
    begin
        ent_we       = 1'b0;
        ent_waddr    = h_idx[SLOT_W-1:0];
        ent_wdata    = ent_rdata;
        ent_raddr    = cmd.alloc_col ? col_slot[SLOT_W-1:0] : h_idx[SLOT_W-1:0];
        fmap_we      = 1'b0;
        fmap_waddr   = row_sel_reg;
        fmap_wdata   = release_row_new;
        rowv_next    = rowv_reg;
        summary_next = summary_reg;
        live_next    = live_reg;
        rej_next     = rej_reg;

        if (cmd.clear)
        begin
            ent_we    = 1'b1;
            ent_waddr = clr_cnt_reg;
            ent_wdata = '0;
        end

        if (cmd.decode && !is_alloc && (is_lookup || is_release) && !static_ok)
        begin
            rej_next = rej_reg + COUNT_W'(1);
        end

        if (cmd.alloc_write)
        begin
            ent_we               = 1'b1;
            ent_waddr            = alloc_slot[SLOT_W-1:0];
            ent_wdata.occupied   = 1'b1;
            ent_wdata.retired    = 1'b0;
            ent_wdata.generation = alloc_gen;
            ent_wdata.payload    = PAYLOAD_BITS'(payload_reg);
            fmap_we              = 1'b1;
            fmap_wdata           = alloc_row_new;
            rowv_next[row_sel_reg]    = 1'b1;
            summary_next[row_sel_reg] = |alloc_row_new;
            live_next            = live_reg + LIVE_W'(1);
        end

        if (cmd.check)
        begin
            if (!slot_ok)
            begin
                rej_next = rej_reg + COUNT_W'(1);
            end
            else if (is_release)
            begin
                ent_we             = 1'b1;
                ent_wdata.occupied = 1'b0;
                ent_wdata.retired  = retiring;
                if (!retiring)
                begin
                    ent_wdata.generation = ent_rdata.generation + GEN_W'(1);
                    fmap_we                   = 1'b1;
                    rowv_next[row_sel_reg]    = 1'b1;
                    summary_next[row_sel_reg] = 1'b1;
                end
                live_next = live_reg - LIVE_W'(1);
            end
        end
    end

    // Slot RAM: occupancy, retirement, generation and payload of each slot.
    ght_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata_raw)
    );

    // Free map RAM: one bit per slot that is neither occupied nor retired.
    ght_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROW_COUNT)
    ) u_fmap_ram (
        .clk   (clk),
        .we    (fmap_we),
        .waddr (fmap_waddr),
        .wdata (fmap_wdata),
        .raddr (dec_row),
        .rdata (fmap_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rowv_reg      <= '0;
            summary_reg   <= '1;
            live_reg      <= '0;
            rej_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            rowv_reg    <= rowv_next;
            summary_reg <= summary_next;
            live_reg    <= live_next;
            rej_reg     <= rej_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, work registers and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= req_type;
            handle_reg  <= handle_in;
            payload_reg <= payload_in;
        end

        if (cmd.decode)
        begin
            row_sel_reg      <= dec_row;
            pend_status_reg  <= ST_OK;
            pend_handle_reg  <= '0;
            pend_payload_reg <= '0;
            if (is_alloc && (summary_reg == '0))
            begin
                pend_status_reg <= ST_FULL;
            end
            else if ((is_lookup || is_release) && !static_ok)
            begin
                pend_status_reg <= ST_REJECT;
            end
        end

        if (cmd.alloc_col)
        begin
            col_reg      <= first_col;
            row_data_reg <= fmap_eff;
        end

        if (cmd.alloc_write)
        begin
            pend_handle_reg <= {KIND_VALUE, alloc_gen,
                                FIELD_W'(alloc_slot) + FIELD_W'(1)};
        end

        if (cmd.check)
        begin
            if (!slot_ok)
            begin
                pend_status_reg <= ST_REJECT;
            end
            else if (is_lookup)
            begin
                pend_payload_reg <= DATA_W'(ent_rdata.payload);
            end
        end

        if (cmd.emit)
        begin
            out_status_reg  <= pend_status_reg;
            out_handle_reg  <= pend_handle_reg;
            out_payload_reg <= pend_payload_reg;
            out_live_reg    <= live_reg;
            out_rej_reg     <= rej_reg;
        end
    end

    // Status for the controller.
    always_comb
    begin
        sts.clear_last    = (clr_cnt_reg == SLOT_W'(SLOT_COUNT - 1));
        sts.is_alloc      = is_alloc;
        sts.is_handle_req = is_lookup || is_release;
        sts.full          = (summary_reg == '0);
        sts.static_ok     = static_ok;
        sts.out_free      = !out_valid_reg || !out_stall;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign handle_out     = out_handle_reg;
    assign payload_out    = out_payload_reg;
    assign live_count     = out_live_reg;
    assign rejected_count = out_rej_reg;

endmodule

@@ rtl/core/generational_handle_table.sv @@
// Top level of the generational handle table.
`timescale 1ns / 1ps

// Generational handle table: allocate, look up and release 32-bit handles that
// carry kind 3, a 12-bit slot generation and the slot number plus one. After
// reset the block clears its slot RAM, one slot per cycle, and holds in_stall
// high meanwhile. It then serves one request at a time through a small
// sequencer: a rejected handle, a full table or an unused request type passes
// through the decode and result states, a lookup or release through decode,
// check and result, an allocate through decode, column search, write and
// result; these steps follow the registered reads of the slot RAM and of the
// free map RAM, which the allocate path reads one after the other. A result
// waits in an output register, and a new request is accepted while it does.
module generational_handle_table
    import ght_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [HANDLE_W-1:0] handle_in,
    input  logic [DATA_W-1:0]   payload_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [DATA_W-1:0]   payload_out,
    output logic [LIVE_W-1:0]   live_count,
    output logic [COUNT_W-1:0]  rejected_count
);

    ght_cmd_t cmd;
    ght_sts_t sts;

    // Request sequencer.
    ght_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, search and result datapath.
    ght_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .handle_in      (handle_in),
        .payload_in     (payload_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .handle_out     (handle_out),
        .payload_out    (payload_out),
        .live_count     (live_count),
        .rejected_count (rejected_count)
    );

endmodule
